// ----- hdl/lpg_pkg.sv -----
// Shared types and constants for the line pixel generator.
// No dependencies; every other file of the block refers to this package.
package lpg_pkg;

	typedef enum logic {
		CMD_START   = 1'b0,
		CMD_ADVANCE = 1'b1
	} cmd_t;

	localparam int REG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_SCREEN_WIDTH    = 2'd0,
		REG_SCREEN_HEIGHT   = 2'd1,
		REG_ROW_BYTES       = 2'd2,
		REG_BYTES_PER_PIXEL = 2'd3
	} reg_idx_t;

	localparam int SCREEN_DIM_W = 13;
	localparam int ROW_BYTES_W  = 16;
	localparam int BPP_W        = 4;
	localparam int COLOR_W      = 32;
	localparam int OFFSET_W     = 32;

	localparam logic [SCREEN_DIM_W-1:0] SCREEN_WIDTH_RST    = 13'd1920;
	localparam logic [SCREEN_DIM_W-1:0] SCREEN_HEIGHT_RST   = 13'd1080;
	localparam logic [ROW_BYTES_W-1:0]  ROW_BYTES_RST       = 16'd7680;
	localparam logic [BPP_W-1:0]        BYTES_PER_PIXEL_RST = 4'd4;

endpackage

// ----- hdl/lpg_if.sv -----
// Valid/ready channel interfaces for line commands and produced pixels.
// Depends on lpg_pkg for the command code and field widths.
interface lpg_cmd_if #(parameter int COORD_WIDTH = 16);
	logic                             valid;
	logic                             ready;
	lpg_pkg::cmd_t                    command;
	logic signed [COORD_WIDTH-1:0]    start_x;
	logic signed [COORD_WIDTH-1:0]    start_y;
	logic signed [COORD_WIDTH-1:0]    end_x;
	logic signed [COORD_WIDTH-1:0]    end_y;
	logic [lpg_pkg::COLOR_W-1:0]      line_color;

	modport source (output valid, command, start_x, start_y, end_x, end_y, line_color,
		input ready);
	modport sink (input valid, command, start_x, start_y, end_x, end_y, line_color,
		output ready);
endinterface

interface lpg_pix_if #(parameter int COORD_WIDTH = 16);
	logic                             valid;
	logic                             ready;
	logic signed [COORD_WIDTH-1:0]    pixel_x;
	logic signed [COORD_WIDTH-1:0]    pixel_y;
	logic [lpg_pkg::COLOR_W-1:0]      pixel_value;
	logic                             inside_res;
	logic [lpg_pkg::OFFSET_W-1:0]     byte_offset;
	logic                             last;

	modport source (output valid, pixel_x, pixel_y, pixel_value, inside_res, byte_offset, last,
		input ready);
	modport sink (input valid, pixel_x, pixel_y, pixel_value, inside_res, byte_offset, last,
		output ready);
endinterface

// ----- hdl/line_pixel_generator_unit.sv -----
// Top level of the Bresenham line pixel generator.
// Depends on lpg_pkg, lpg_if, lpg_step and lpg_pixel.
//
//  Channel  Dir  Handshake      Carries
//  cmd      in   valid/ready    command, start_x, start_y, end_x, end_y, line_color
//  pix      out  valid/ready    pixel_x, pixel_y, pixel_value, inside_res, byte_offset, last
//  cfg      in   cfg_we only    cfg_index, cfg_data
//
// One command is taken per clock unless the point register is full and stalled.
// The error step and end-point compare run in the cycle of the transfer, ending in the
// point register; the clip test and offset multiply follow, ending in the result register.
// Reset clears the active line and both valid flags and loads the register defaults.
// A stalled pix channel holds its result; commands keep flowing until the point
// register behind it is full as well.
module line_pixel_generator_unit #(
	parameter int COORD_WIDTH = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [lpg_pkg::REG_IDX_W-1:0]  cfg_index,
	input  logic [lpg_pkg::CFG_DATA_W-1:0] cfg_data,
	lpg_cmd_if.sink                        cmd,
	lpg_pix_if.source                      pix
);
	logic                          pt_valid, pt_ready, pt_last;
	logic signed [COORD_WIDTH-1:0] pt_x, pt_y;
	logic [lpg_pkg::COLOR_W-1:0]   pt_color;

	lpg_step #(.COORD_WIDTH(COORD_WIDTH)) u_step (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (cmd.valid),
		.in_ready    (cmd.ready),
		.command     (cmd.command),
		.start_x     (cmd.start_x),
		.start_y     (cmd.start_y),
		.end_x       (cmd.end_x),
		.end_y       (cmd.end_y),
		.line_color  (cmd.line_color),
		.pt_valid_s1 (pt_valid),
		.pt_ready    (pt_ready),
		.pt_x_s1     (pt_x),
		.pt_y_s1     (pt_y),
		.pt_color_s1 (pt_color),
		.pt_last_s1  (pt_last)
	);

	lpg_pixel #(.COORD_WIDTH(COORD_WIDTH)) u_pixel (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.pt_valid       (pt_valid),
		.pt_ready       (pt_ready),
		.pt_x           (pt_x),
		.pt_y           (pt_y),
		.pt_color       (pt_color),
		.pt_last        (pt_last),
		.out_valid_s2   (pix.valid),
		.out_ready      (pix.ready),
		.pixel_x_s2     (pix.pixel_x),
		.pixel_y_s2     (pix.pixel_y),
		.pixel_value_s2 (pix.pixel_value),
		.inside_s2      (pix.inside_res),
		.byte_offset_s2 (pix.byte_offset),
		.last_s2        (pix.last)
	);

endmodule

// ----- hdl/lpg_step.sv -----
// Bresenham stepper: line state, one error-term step per accepted advance of an active line.
// Depends on lpg_pkg; feeds the point register read by lpg_pixel.
module lpg_step #(
	parameter int COORD_WIDTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  lpg_pkg::cmd_t                 command,
	input  logic signed [COORD_WIDTH-1:0] start_x,
	input  logic signed [COORD_WIDTH-1:0] start_y,
	input  logic signed [COORD_WIDTH-1:0] end_x,
	input  logic signed [COORD_WIDTH-1:0] end_y,
	input  logic [lpg_pkg::COLOR_W-1:0]   line_color,
	output logic                          pt_valid_s1,
	input  logic                          pt_ready,
	output logic signed [COORD_WIDTH-1:0] pt_x_s1,
	output logic signed [COORD_WIDTH-1:0] pt_y_s1,
	output logic [lpg_pkg::COLOR_W-1:0]   pt_color_s1,
	output logic                          pt_last_s1
);
	localparam int SW = COORD_WIDTH + 1;
	localparam int NW = COORD_WIDTH + 2;
	localparam int EW = COORD_WIDTH + 3;
	localparam int DW = COORD_WIDTH + 4;

	logic signed [COORD_WIDTH-1:0] cur_x_q, cur_y_q, tgt_x_q, tgt_y_q;
	logic                          neg_x_q, neg_y_q;
	logic [SW-1:0]                 span_x_q;
	logic signed [NW-1:0]          span_y_neg_q;
	logic signed [EW-1:0]          err_q;
	logic [lpg_pkg::COLOR_W-1:0]   color_q;
	logic                          active_q;

	logic                          accept, is_start, emit;
	logic signed [SW-1:0]          dx, dy;
	logic [SW-1:0]                 abs_dx, abs_dy;
	logic signed [NW-1:0]          st_span_y_neg;
	logic signed [EW-1:0]          st_err;
	logic signed [EW-1:0]          span_x_e;
	logic signed [DW-1:0]          e2, syn_ext, sx_ext;
	logic                          step_x, step_y;
	logic signed [EW-1:0]          adv_err;
	logic signed [COORD_WIDTH-1:0] adv_x, adv_y, nxt_x, nxt_y, nxt_tx, nxt_ty;
	logic                          nxt_last;

	assign in_ready = !pt_valid_s1 || pt_ready;
	assign accept   = in_valid && in_ready;
	assign is_start = (command == lpg_pkg::CMD_START);
	assign emit     = is_start || active_q;

	// Line setup from the endpoints.
	assign dx            = SW'(end_x) - SW'(start_x);
	assign dy            = SW'(end_y) - SW'(start_y);
	assign abs_dx        = dx[SW-1] ? SW'(-dx) : SW'(dx);
	assign abs_dy        = dy[SW-1] ? SW'(-dy) : SW'(dy);
	assign st_span_y_neg = -$signed(NW'(abs_dy));
	assign st_err        = EW'($signed({1'b0, abs_dx})) + EW'(st_span_y_neg);

	// One error-term step; both axes may move in the same step.
	assign span_x_e = EW'($signed({1'b0, span_x_q}));
	assign e2       = {err_q, 1'b0};
	assign syn_ext  = DW'(span_y_neg_q);
	assign sx_ext   = DW'(span_x_e);
	assign step_x   = (e2 >= syn_ext);
	assign step_y   = (e2 <= sx_ext);
	assign adv_err  = err_q + (step_x ? EW'(span_y_neg_q) : EW'(0))
		+ (step_y ? span_x_e : EW'(0));
	assign adv_x    = step_x ? (neg_x_q ? cur_x_q - 1'b1 : cur_x_q + 1'b1) : cur_x_q;
	assign adv_y    = step_y ? (neg_y_q ? cur_y_q - 1'b1 : cur_y_q + 1'b1) : cur_y_q;

	assign nxt_x    = is_start ? start_x : adv_x;
	assign nxt_y    = is_start ? start_y : adv_y;
	assign nxt_tx   = is_start ? end_x : tgt_x_q;
	assign nxt_ty   = is_start ? end_y : tgt_y_q;
	assign nxt_last = (nxt_x == nxt_tx) && (nxt_y == nxt_ty);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			pt_valid_s1 <= 1'b0;
		end else begin
			if (accept && emit) begin
				active_q <= !nxt_last;
			end
			if (in_ready) begin
				pt_valid_s1 <= accept && emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && is_start) begin
			tgt_x_q      <= end_x;
			tgt_y_q      <= end_y;
			neg_x_q      <= !(start_x < end_x);
			neg_y_q      <= !(start_y < end_y);
			span_x_q     <= abs_dx;
			span_y_neg_q <= st_span_y_neg;
			color_q      <= line_color;
			err_q        <= st_err;
			cur_x_q      <= start_x;
			cur_y_q      <= start_y;
		end else if (accept && active_q) begin
			err_q   <= adv_err;
			cur_x_q <= adv_x;
			cur_y_q <= adv_y;
		end
		if (accept && emit) begin
			pt_x_s1     <= nxt_x;
			pt_y_s1     <= nxt_y;
			pt_color_s1 <= is_start ? line_color : color_q;
			pt_last_s1  <= nxt_last;
		end
	end

	a_start_emits: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && is_start) |=> pt_valid_s1)
		else $error("start command produced no point");

	a_idle_advance_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !is_start && !active_q && !pt_valid_s1) |=> !pt_valid_s1)
		else $error("advance without an active line produced a point");

	a_single_point_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && is_start && start_x == end_x && start_y == end_y) |=> !active_q)
		else $error("single-point line left the stepper active");

	a_last_ends_line: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !is_start && active_q && nxt_last) |=> !active_q)
		else $error("line still active after its end point");

endmodule

// ----- hdl/lpg_pixel.sv -----
// Output stage: configuration registers, screen clipping and byte offset.
// Depends on lpg_pkg; takes points from lpg_step and holds the result register.
module lpg_pixel #(
	parameter int COORD_WIDTH = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [lpg_pkg::REG_IDX_W-1:0]       cfg_index,
	input  logic [lpg_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                pt_valid,
	output logic                                pt_ready,
	input  logic signed [COORD_WIDTH-1:0]       pt_x,
	input  logic signed [COORD_WIDTH-1:0]       pt_y,
	input  logic [lpg_pkg::COLOR_W-1:0]         pt_color,
	input  logic                                pt_last,
	output logic                                out_valid_s2,
	input  logic                                out_ready,
	output logic signed [COORD_WIDTH-1:0]       pixel_x_s2,
	output logic signed [COORD_WIDTH-1:0]       pixel_y_s2,
	output logic [lpg_pkg::COLOR_W-1:0]         pixel_value_s2,
	output logic                                inside_s2,
	output logic [lpg_pkg::OFFSET_W-1:0]        byte_offset_s2,
	output logic                                last_s2
);
	localparam int DIM_W = lpg_pkg::SCREEN_DIM_W;
	localparam int CMPW  = (COORD_WIDTH > DIM_W) ? COORD_WIDTH : DIM_W;

	logic [DIM_W-1:0]                scr_w_q, scr_h_q;
	logic [lpg_pkg::ROW_BYTES_W-1:0] row_bytes_q;
	logic [lpg_pkg::BPP_W-1:0]       bpp_q;

	logic [CMPW-1:0]                 xu, yu;
	logic                            on_screen;
	logic [DIM_W+lpg_pkg::ROW_BYTES_W-1:0] prod_y;
	logic [DIM_W+lpg_pkg::BPP_W-1:0]       prod_x;
	logic [lpg_pkg::OFFSET_W-1:0]    offset;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scr_w_q     <= lpg_pkg::SCREEN_WIDTH_RST;
			scr_h_q     <= lpg_pkg::SCREEN_HEIGHT_RST;
			row_bytes_q <= lpg_pkg::ROW_BYTES_RST;
			bpp_q       <= lpg_pkg::BYTES_PER_PIXEL_RST;
		end else if (cfg_we) begin
			unique case (lpg_pkg::reg_idx_t'(cfg_index))
				lpg_pkg::REG_SCREEN_WIDTH:    scr_w_q     <= cfg_data[DIM_W-1:0];
				lpg_pkg::REG_SCREEN_HEIGHT:   scr_h_q     <= cfg_data[DIM_W-1:0];
				lpg_pkg::REG_ROW_BYTES:       row_bytes_q <= cfg_data[lpg_pkg::ROW_BYTES_W-1:0];
				lpg_pkg::REG_BYTES_PER_PIXEL: bpp_q       <= cfg_data[lpg_pkg::BPP_W-1:0];
			endcase
		end
	end

	// A point on screen has both coordinates below 2**13, so the low bits
	// are all the multipliers need.
	assign xu        = CMPW'($unsigned(pt_x));
	assign yu        = CMPW'($unsigned(pt_y));
	assign on_screen = !pt_x[COORD_WIDTH-1] && !pt_y[COORD_WIDTH-1]
		&& (xu < CMPW'(scr_w_q)) && (yu < CMPW'(scr_h_q));
	assign prod_y = yu[DIM_W-1:0] * row_bytes_q;
	assign prod_x = xu[DIM_W-1:0] * bpp_q;
	assign offset = on_screen ? (lpg_pkg::OFFSET_W'(prod_y) + lpg_pkg::OFFSET_W'(prod_x))
		: '0;

	assign pt_ready = !out_valid_s2 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (pt_ready) begin
			out_valid_s2 <= pt_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pt_valid && pt_ready) begin
			pixel_x_s2     <= pt_x;
			pixel_y_s2     <= pt_y;
			pixel_value_s2 <= pt_color;
			inside_s2      <= on_screen;
			byte_offset_s2 <= offset;
			last_s2        <= pt_last;
		end
	end

	a_clip_zero_offset: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_s2 && !inside_s2) |-> (byte_offset_s2 == '0))
		else $error("clipped pixel carries a nonzero offset");

	a_point_reaches_output: assert property (@(posedge clk) disable iff (!arst_n)
		(pt_valid && pt_ready) |=> out_valid_s2)
		else $error("transferred point did not reach the result register");

	a_zero_width_clips: assert property (@(posedge clk) disable iff (!arst_n)
		(pt_valid && scr_w_q == '0) |-> !on_screen)
		else $error("point inside a screen of zero width");

endmodule

// ----- tb/line_pixel_generator_unit_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for line_pixel_generator_unit: start/advance line commands in,
// predicted pixels compared field by field. Depends on lpg_pkg, lpg_if and the unit itself.
module line_pixel_generator_unit_tb;

	localparam int CW          = 16;
	localparam int CYCLE_LIMIT = 400000;
	localparam int LONG_HOLD   = 150;

	typedef struct {
		lpg_pkg::cmd_t               command;
		logic signed [CW-1:0]        start_x;
		logic signed [CW-1:0]        start_y;
		logic signed [CW-1:0]        end_x;
		logic signed [CW-1:0]        end_y;
		logic [lpg_pkg::COLOR_W-1:0] color;
	} line_cmd_t;

	typedef struct {
		logic signed [CW-1:0]         x;
		logic signed [CW-1:0]         y;
		logic [lpg_pkg::COLOR_W-1:0]  value;
		logic                         on_screen;
		logic [lpg_pkg::OFFSET_W-1:0] offset;
		logic                         last;
	} pixel_t;

	typedef enum {RDY_ALWAYS, RDY_HALF, RDY_SPARSE, RDY_TOGGLE, RDY_MOSTLY} ready_mode_t;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           cfg_we = 1'b0;
	logic [lpg_pkg::REG_IDX_W-1:0]  cfg_index = '0;
	logic [lpg_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	lpg_cmd_if #(.COORD_WIDTH(CW)) cmd_ch ();
	lpg_pix_if #(.COORD_WIDTH(CW)) pix_ch ();

	line_pixel_generator_unit #(.COORD_WIDTH(CW)) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd_ch),
		.pix       (pix_ch)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Register copies and line state of the predictor.
	logic [lpg_pkg::SCREEN_DIM_W-1:0] scr_width  = lpg_pkg::SCREEN_WIDTH_RST;
	logic [lpg_pkg::SCREEN_DIM_W-1:0] scr_height = lpg_pkg::SCREEN_HEIGHT_RST;
	logic [lpg_pkg::ROW_BYTES_W-1:0]  row_pitch  = lpg_pkg::ROW_BYTES_RST;
	logic [lpg_pkg::BPP_W-1:0]        pix_bytes  = lpg_pkg::BYTES_PER_PIXEL_RST;

	logic signed [CW-1:0]        pen_x = '0;
	logic signed [CW-1:0]        pen_y = '0;
	logic signed [CW-1:0]        goal_x = '0;
	logic signed [CW-1:0]        goal_y = '0;
	logic                        dir_x_neg = 1'b0;
	logic                        dir_y_neg = 1'b0;
	logic [CW:0]                 run_x = '0;
	logic signed [CW+1:0]        rise_neg = '0;
	logic signed [CW+2:0]        slope_err = '0;
	logic [lpg_pkg::COLOR_W-1:0] line_rgb = '0;
	logic                        drawing = 1'b0;

	line_cmd_t pending_cmds[$];
	pixel_t    expected_pixels[$];
	line_cmd_t taken_cmd;
	pixel_t    want_pix;

	logic cmd_took = 1'b0;
	int   burst_left = 0;
	int   gap_left = 0;
	int   hold_seq = 0;
	int   hold_seen = 0;
	int   hold_left = 0;
	int   mode_left = 0;
	ready_mode_t rdy_mode = RDY_ALWAYS;
	int   fault_count = 0;
	int   cycle_count = 0;

	// One Bresenham step (or a line start) and the pixel it yields, if any.
	function automatic void trace_line_step(input line_cmd_t c);
		int           dx;
		int           dy;
		int           e2;
		pixel_t       p;
		logic [31:0]  ux;
		logic [31:0]  uy;
		if (c.command == lpg_pkg::CMD_START) begin
			pen_x     = c.start_x;
			pen_y     = c.start_y;
			goal_x    = c.end_x;
			goal_y    = c.end_y;
			line_rgb  = c.color;
			dir_x_neg = !(c.start_x < c.end_x);
			dir_y_neg = !(c.start_y < c.end_y);
			dx        = int'(c.end_x) - int'(c.start_x);
			dy        = int'(c.end_y) - int'(c.start_y);
			run_x     = (CW+1)'((dx < 0) ? -dx : dx);
			rise_neg  = (CW+2)'((dy < 0) ? dy : -dy);
			slope_err = (CW+3)'(int'(run_x) + int'(rise_neg));
		end else begin
			if (!drawing)
				return;
			e2 = 2 * int'(slope_err);
			if (e2 >= int'(rise_neg)) begin
				slope_err = (CW+3)'(int'(slope_err) + int'(rise_neg));
				pen_x     = CW'(dir_x_neg ? pen_x - 1 : pen_x + 1);
			end
			if (e2 <= int'(run_x)) begin
				slope_err = (CW+3)'(int'(slope_err) + int'(run_x));
				pen_y     = CW'(dir_y_neg ? pen_y - 1 : pen_y + 1);
			end
		end
		p.x         = pen_x;
		p.y         = pen_y;
		p.value     = line_rgb;
		p.on_screen = pen_x >= 0 && int'(pen_x) < int'(scr_width) &&
			pen_y >= 0 && int'(pen_y) < int'(scr_height);
		ux          = 32'(pen_x);
		uy          = 32'(pen_y);
		p.offset    = p.on_screen ? uy * 32'(row_pitch) + ux * 32'(pix_bytes) : '0;
		p.last      = (pen_x == goal_x) && (pen_y == goal_y);
		drawing     = !p.last;
		expected_pixels.push_back(p);
	endfunction

	// Command side: every transfer feeds the predictor.
	always @(posedge clk) begin
		if (arst_n && cmd_ch.valid && cmd_ch.ready) begin
			taken_cmd = pending_cmds.pop_front();
			trace_line_step(taken_cmd);
		end
		cmd_took <= arst_n && cmd_ch.valid && cmd_ch.ready;
	end

	// Sender: bursts of random length, random gaps; an offer is held until taken.
	always @(negedge clk) begin
		if (!arst_n) begin
			cmd_ch.valid <= 1'b0;
		end else if (!cmd_ch.valid || cmd_took) begin
			if (gap_left > 0) begin
				cmd_ch.valid <= 1'b0;
				gap_left--;
			end else if (pending_cmds.size() > 0) begin
				cmd_ch.valid      <= 1'b1;
				cmd_ch.command    <= pending_cmds[0].command;
				cmd_ch.start_x    <= pending_cmds[0].start_x;
				cmd_ch.start_y    <= pending_cmds[0].start_y;
				cmd_ch.end_x      <= pending_cmds[0].end_x;
				cmd_ch.end_y      <= pending_cmds[0].end_y;
				cmd_ch.line_color <= pending_cmds[0].color;
				if (burst_left > 1) begin
					burst_left--;
				end else begin
					burst_left = ($urandom_range(0, 9) == 0) ? 80 : $urandom_range(1, 12);
					gap_left   = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 6);
				end
			end else begin
				cmd_ch.valid <= 1'b0;
			end
		end
	end

	// Receiver: a changing stall pattern, plus a long hold-off whenever one is requested.
	always @(negedge clk) begin
		if (hold_seen != hold_seq) begin
			hold_seen = hold_seq;
			hold_left = LONG_HOLD;
		end
		if (hold_left > 0) begin
			hold_left--;
			pix_ch.ready <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				rdy_mode  = ready_mode_t'($urandom_range(0, 4));
				mode_left = $urandom_range(20, 80);
			end else begin
				mode_left--;
			end
			case (rdy_mode)
				RDY_ALWAYS: pix_ch.ready <= 1'b1;
				RDY_HALF:   pix_ch.ready <= ($urandom_range(0, 1) == 1);
				RDY_SPARSE: pix_ch.ready <= ($urandom_range(0, 4) == 0);
				RDY_TOGGLE: pix_ch.ready <= !pix_ch.ready;
				default:    pix_ch.ready <= ($urandom_range(0, 3) != 0);
			endcase
		end
	end

	// Pixel side: each transfer is checked against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && pix_ch.valid && pix_ch.ready) begin
			if (expected_pixels.size() == 0) begin
				fault_count++;
				if (fault_count <= 10)
					$display("unexpected pixel x=%0d y=%0d", pix_ch.pixel_x, pix_ch.pixel_y);
			end else begin
				want_pix = expected_pixels.pop_front();
				if (pix_ch.pixel_x !== want_pix.x || pix_ch.pixel_y !== want_pix.y ||
						pix_ch.pixel_value !== want_pix.value ||
						pix_ch.inside_res !== want_pix.on_screen ||
						pix_ch.byte_offset !== want_pix.offset ||
						pix_ch.last !== want_pix.last) begin
					fault_count++;
					if (fault_count <= 10)
						$display("pixel mismatch: expected x=%0d y=%0d val=%h in=%b off=%h last=%b,",
							want_pix.x, want_pix.y, want_pix.value, want_pix.on_screen,
							want_pix.offset, want_pix.last,
							" got x=%0d y=%0d val=%h in=%b off=%h last=%b",
							pix_ch.pixel_x, pix_ch.pixel_y, pix_ch.pixel_value,
							pix_ch.inside_res, pix_ch.byte_offset, pix_ch.last);
				end
			end
		end
	end

	function automatic int clamp_coord(input int v);
		if (v > 32767)
			return 32767;
		if (v < -32768)
			return -32768;
		return v;
	endfunction

	function automatic int any_coord();
		return int'($urandom_range(0, 65535)) - 32768;
	endfunction

	// A coordinate around zero, around the clip limit, or anywhere on screen.
	function automatic int coord_near(input int lim);
		case ($urandom_range(0, 2))
			0:       return int'($urandom_range(0, 8)) - 4;
			1:       return lim + int'($urandom_range(0, 8)) - 4;
			default: return int'($urandom_range(0, lim));
		endcase
	endfunction

	function automatic int abs_int(input int v);
		return (v < 0) ? -v : v;
	endfunction

	// A start command, then a number of advances; the advances carry junk endpoint fields.
	task automatic queue_line(input int sx, input int sy, input int ex, input int ey,
			input logic [lpg_pkg::COLOR_W-1:0] rgb, input int steps);
		line_cmd_t c;
		c.command = lpg_pkg::CMD_START;
		c.start_x = CW'(sx);
		c.start_y = CW'(sy);
		c.end_x   = CW'(ex);
		c.end_y   = CW'(ey);
		c.color   = rgb;
		pending_cmds.push_back(c);
		repeat (steps) begin
			c.command = lpg_pkg::CMD_ADVANCE;
			c.start_x = CW'($urandom());
			c.start_y = CW'($urandom());
			c.end_x   = CW'($urandom());
			c.end_y   = CW'($urandom());
			c.color   = $urandom();
			pending_cmds.push_back(c);
		end
	endtask

	task automatic queue_random_lines(input int quota);
		int made;
		int kind;
		int sx;
		int sy;
		int ex;
		int ey;
		int span;
		int steps;
		made = 0;
		while (made < quota) begin
			kind = $urandom_range(0, 99);
			if (kind < 55) begin
				sx = coord_near(int'(scr_width));
				sy = coord_near(int'(scr_height));
				ex = clamp_coord(sx + int'($urandom_range(0, 24)) - 12);
				ey = clamp_coord(sy + int'($urandom_range(0, 24)) - 12);
			end else if (kind < 70) begin
				sx = any_coord();
				sy = any_coord();
				ex = clamp_coord(sx + int'($urandom_range(0, 40)) - 20);
				ey = clamp_coord(sy + int'($urandom_range(0, 40)) - 20);
			end else if (kind < 85) begin
				sx = any_coord();
				sy = any_coord();
				ex = any_coord();
				ey = any_coord();
			end else if (kind < 95) begin
				sx = coord_near(int'(scr_width));
				sy = coord_near(int'(scr_height));
				ex = sx;
				ey = sy;
				case ($urandom_range(0, 2))
					0:       ey = clamp_coord(sy + int'($urandom_range(0, 30)) - 15);
					1:       ex = clamp_coord(sx + int'($urandom_range(0, 30)) - 15);
					default: ;
				endcase
			end else begin
				sx   = coord_near(int'(scr_width));
				sy   = coord_near(int'(scr_height));
				span = $urandom_range(1, 12);
				ex   = clamp_coord($urandom_range(0, 1) ? sx + span : sx - span);
				ey   = clamp_coord($urandom_range(0, 1) ? sy + span : sy - span);
			end
			span = abs_int(ex - sx) > abs_int(ey - sy) ? abs_int(ex - sx) : abs_int(ey - sy);
			// Long lines are cut short and abandoned by the next start.
			steps = (kind >= 70 && kind < 85) ? $urandom_range(0, 6) : span;
			if (steps > span)
				steps = span;
			made += 1 + steps;
			// Now and then a finished line is followed by advances that must be ignored.
			if (steps == span && $urandom_range(0, 4) == 0)
				steps += $urandom_range(1, 2);
			queue_line(sx, sy, ex, ey, $urandom(), steps);
		end
	endtask

	task automatic write_reg(input lpg_pkg::reg_idx_t idx,
			input logic [lpg_pkg::CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		case (idx)
			lpg_pkg::REG_SCREEN_WIDTH:  scr_width  = value[lpg_pkg::SCREEN_DIM_W-1:0];
			lpg_pkg::REG_SCREEN_HEIGHT: scr_height = value[lpg_pkg::SCREEN_DIM_W-1:0];
			lpg_pkg::REG_ROW_BYTES:     row_pitch  = value[lpg_pkg::ROW_BYTES_W-1:0];
			default:                    pix_bytes  = value[lpg_pkg::BPP_W-1:0];
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_screen(input int w, input int h, input int pitch, input int bpp);
		write_reg(lpg_pkg::REG_SCREEN_WIDTH, lpg_pkg::CFG_DATA_W'(w));
		write_reg(lpg_pkg::REG_SCREEN_HEIGHT, lpg_pkg::CFG_DATA_W'(h));
		write_reg(lpg_pkg::REG_ROW_BYTES, lpg_pkg::CFG_DATA_W'(pitch));
		write_reg(lpg_pkg::REG_BYTES_PER_PIXEL, lpg_pkg::CFG_DATA_W'(bpp));
	endtask

	// Wait until every queued command is taken and every pixel has come back, then let the
	// unit settle, since trailing idle advances produce nothing.
	task automatic drain();
		while (pending_cmds.size() != 0 || expected_pixels.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		cmd_ch.valid      = 1'b0;
		cmd_ch.command    = lpg_pkg::CMD_ADVANCE;
		cmd_ch.start_x    = '0;
		cmd_ch.start_y    = '0;
		cmd_ch.end_x      = '0;
		cmd_ch.end_y      = '0;
		cmd_ch.line_color = '0;
		pix_ch.ready      = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed lines at the default screen setup.
		queue_line(0, 0, 0, 0, 32'h0000_0000, 1);
		queue_line(-32768, -32768, 32767, 32767, 32'hFFFF_FFFF, 2);
		queue_line(32767, 32767, -32768, -32768, 32'h0000_0000, 2);
		queue_line(5, 5, 5, 8, 32'h1234_5678, 4);
		queue_line(10, 3, 7, 3, 32'h8765_4321, 3);
		queue_line(1918, 1077, 1921, 1082, 32'hA5A5_5A5A, 5);
		queue_line(1919, 1079, 1919, 1079, 32'h5A5A_A5A5, 0);
		queue_line(1920, 0, 1920, 0, 32'hDEAD_BEEF, 0);
		queue_line(0, 1080, 0, 1080, 32'hCAFE_F00D, 0);
		queue_line(-1, 0, -1, 0, 32'h0F0F_F0F0, 0);
		queue_random_lines(80);
		drain();

		// Zero screen and zero offset terms: everything is clipped.
		set_screen(0, 0, 0, 0);
		queue_random_lines(60);
		drain();

		// Largest settings, with a long hold-off at the receiver so the unit backs up.
		set_screen(8191, 8191, 65535, 15);
		queue_random_lines(120);
		@(posedge clk);
		hold_seq++;
		drain();

		set_screen(1, 1, 1, 1);
		queue_random_lines(60);
		drain();

		set_screen(4096, 4096, 16384, 8);
		queue_random_lines(100);
		drain();

		repeat (3) begin
			set_screen($urandom_range(1, 4096), $urandom_range(1, 4096),
				$urandom_range(0, 65535), $urandom_range(1, 8));
			queue_random_lines(140);
			@(posedge clk);
			if ($urandom_range(0, 1))
				hold_seq++;
			drain();
		end

		repeat (8) @(posedge clk);
		if (fault_count == 0 && expected_pixels.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
